@@ hdl/idpd_pkg.sv @@
`default_nettype none

package idpd_pkg;

    // Width of internal store addresses; covers the largest mask offset at any store size.
    localparam int ADDR_W = 21;

    // Frames wider or taller than this are clipped to it.
    localparam logic [8:0] MAX_SIDE = 9'd256;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Transaction kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DEPTH = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_ROWS     = 2'd1;
    localparam logic [1:0] CFG_BITS_PER_PIXEL = 2'd2;
    localparam logic [1:0] CFG_PALETTE_COLORS = 2'd3;

    // Supported color depths.
    localparam logic [5:0] DEPTH_1  = 6'd1;
    localparam logic [5:0] DEPTH_4  = 6'd4;
    localparam logic [5:0] DEPTH_8  = 6'd8;
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_32 = 6'd32;

    // Alpha values taken from the AND mask.
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Pixel decoding mode, one per supported depth.
    typedef enum logic [2:0] {
        MODE_PAL1 = 3'd0,
        MODE_PAL4 = 3'd1,
        MODE_PAL8 = 3'd2,
        MODE_RGB  = 3'd3,
        MODE_RGBA = 3'd4
    } mode_t;

    // Configuration register contents.
    typedef struct packed {
        logic [8:0] image_width;
        logic [8:0] image_rows;
        logic [5:0] bits_per_pixel;
        logic [7:0] palette_colors;
    } cfg_t;

    // One classified transaction passed from the front to the back.
    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        mode_t             mode;
        logic [18:0]       waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] col_addr;
        logic [ADDR_W-1:0] and_addr;
        logic [7:0]        x;
        logic [7:0]        dest_row;
    } entry_t;

endpackage

`default_nettype wire

@@ hdl/idpd_front.sv @@
`default_nettype none

module idpd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             kind,
    input  wire logic [18:0]      byte_address,
    input  wire logic [7:0]       data_byte,
    input  wire logic [7:0]       pixel_x,
    input  wire logic [7:0]       pixel_y,
    input  idpd_pkg::cfg_t        cfg,
    input  wire logic             q_full,
    output logic                  push,
    output idpd_pkg::entry_t      push_data
);
    import idpd_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CALC = 4'b0010,
        F_MUL  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg;
    fstate_t state_next;

    logic        kind_reg;
    logic [18:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;

    logic [8:0]  h_reg;
    logic [10:0] pitch_reg;
    logic [6:0]  apitch_reg;
    logic [10:0] xbase_reg;
    logic [1:0]  status_reg;
    mode_t       mode_reg;

    logic [19:0] hp_reg;
    logic [18:0] yp_reg;
    logic [14:0] ya_reg;

    logic        accept;
    logic [8:0]  w_lim;
    logic [8:0]  h_lim;
    logic        depth_ok;
    mode_t       mode_calc;
    logic [13:0] bits;
    logic [13:0] bits_round;
    logic [9:0]  w_round;
    logic [8:0]  colors;
    logic [1:0]  status_calc;
    logic [9:0]  col_off;
    logic [ADDR_W-1:0] row_addr;

    assign accept = start && (state_reg == F_IDLE);
    assign busy   = (state_reg != F_IDLE);
    assign push   = (state_reg == F_PUSH) && !q_full;

    // Frame size clipped to the largest supported side.
    always_comb
    begin
        w_lim = (cfg.image_width > MAX_SIDE) ? MAX_SIDE : cfg.image_width;
        h_lim = (cfg.image_rows > MAX_SIDE) ? MAX_SIDE : cfg.image_rows;
    end

    // Depth decode.
    always_comb
    begin
        depth_ok  = 1'b1;
        mode_calc = MODE_RGBA;
        unique case (cfg.bits_per_pixel)
            DEPTH_1:  mode_calc = MODE_PAL1;
            DEPTH_4:  mode_calc = MODE_PAL4;
            DEPTH_8:  mode_calc = MODE_PAL8;
            DEPTH_24: mode_calc = MODE_RGB;
            DEPTH_32: mode_calc = MODE_RGBA;
            default:  depth_ok = 1'b0;
        endcase
    end

    // Row pitch in bits, rounded up to whole 32-bit words.
    always_comb
    begin
        case (mode_calc)
            MODE_PAL1: bits = 14'(w_lim);
            MODE_PAL4: bits = 14'(w_lim) << 2;
            MODE_PAL8: bits = 14'(w_lim) << 3;
            MODE_RGB:  bits = (14'(w_lim) << 4) + (14'(w_lim) << 3);
            MODE_RGBA: bits = 14'(w_lim) << 5;
            default:   bits = '0;
        endcase
        bits_round = bits + 14'd31;
        w_round    = 10'(w_lim) + 10'd31;
    end

    // Palette size; zero means a full palette at the indexed depths.
    always_comb
    begin
        colors = {1'b0, cfg.palette_colors};
        if (cfg.palette_colors == 8'd0)
        begin
            case (mode_calc)
                MODE_PAL1: colors = 9'd2;
                MODE_PAL4: colors = 9'd16;
                MODE_PAL8: colors = 9'd256;
                default:   colors = 9'd0;
            endcase
        end
    end

    // Depth is checked before position.
    always_comb
    begin
        if (!depth_ok)
            status_calc = STATUS_DEPTH;
        else if (({1'b0, x_reg} >= w_lim) || ({1'b0, y_reg} >= h_lim))
            status_calc = STATUS_RANGE;
        else
            status_calc = STATUS_OK;
    end

    // Byte offset of the pixel within its color mask row.
    always_comb
    begin
        case (mode_reg)
            MODE_PAL1: col_off = 10'(x_reg[7:3]);
            MODE_PAL4: col_off = 10'(x_reg[7:1]);
            MODE_PAL8: col_off = 10'(x_reg);
            MODE_RGB:  col_off = {2'b00, x_reg} + {1'b0, x_reg, 1'b0};
            MODE_RGBA: col_off = {x_reg, 2'b00};
            default:   col_off = '0;
        endcase
        row_addr = ADDR_W'(xbase_reg) + ADDR_W'(yp_reg);
    end

    // Transaction handed to the queue.
    always_comb
    begin
        push_data.kind     = kind_reg;
        push_data.status   = status_reg;
        push_data.mode     = mode_reg;
        push_data.waddr    = addr_reg;
        push_data.wdata    = data_reg;
        push_data.col_addr = row_addr + ADDR_W'(col_off);
        push_data.and_addr = ADDR_W'(xbase_reg) + ADDR_W'(hp_reg) + ADDR_W'(ya_reg)
                           + ADDR_W'(x_reg[7:3]);
        push_data.x        = x_reg;
        push_data.dest_row = 8'(h_reg - 9'd1 - {1'b0, y_reg});
    end

    // Sequencing: capture, classify, multiply (pixels only), then wait for queue space.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept) state_next = F_CALC;
            F_CALC: state_next = (kind_reg == KIND_WRITE) ? F_PUSH : F_MUL;
            F_MUL:  state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            addr_reg <= byte_address;
            data_reg <= data_byte;
            x_reg    <= pixel_x;
            y_reg    <= pixel_y;
        end
        if (state_reg == F_CALC)
        begin
            h_reg      <= h_lim;
            pitch_reg  <= {bits_round[13:5], 2'b00};
            apitch_reg <= {w_round[9:5], 2'b00};
            xbase_reg  <= {colors, 2'b00};
            status_reg <= status_calc;
            mode_reg   <= mode_calc;
        end
        if (state_reg == F_MUL)
        begin
            hp_reg <= 20'(h_reg) * 20'(pitch_reg);
            yp_reg <= 19'(y_reg) * 19'(pitch_reg);
            ya_reg <= 15'(y_reg) * 15'(apitch_reg);
        end
    end

endmodule

`default_nettype wire

@@ hdl/idpd_queue.sv @@
`default_nettype none

module idpd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  idpd_pkg::entry_t    push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output idpd_pkg::entry_t    head
);
    import idpd_pkg::*;

    entry_t            q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

@@ hdl/idpd_back.sv @@
`default_nettype none

module idpd_back #(
    parameter int STORE_BYTES = 524288
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  idpd_pkg::entry_t    q_head,
    output logic                pop,
    output logic                done,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [7:0]          alpha,
    output logic [7:0]          dest_row,
    output logic [7:0]          dest_col,
    output logic [1:0]          status
);
    import idpd_pkg::*;

    localparam int MEM_AW = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] STORE_LIMIT = ADDR_W'(STORE_BYTES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_WAIT = 4'b0100,
        S_FIN  = 4'b1000
    } bstate_t;

    // Destination of the byte that a read returns in the next cycle.
    typedef enum logic [2:0] {
        TAG_NONE = 3'd0,
        TAG_B    = 3'd1,
        TAG_G    = 3'd2,
        TAG_R    = 3'd3,
        TAG_A    = 3'd4,
        TAG_AND  = 3'd5,
        TAG_IDX  = 3'd6
    } tag_t;

    logic [7:0] mem [STORE_BYTES];

    bstate_t    state_reg;
    bstate_t    state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    tag_t       tag_reg;
    entry_t     ent_reg;
    logic       oob_reg;
    logic [7:0] rdata_reg;
    logic [7:0] b_reg;
    logic [7:0] g_reg;
    logic [7:0] r_reg;
    logic [7:0] a_reg;
    logic [7:0] and_reg;
    logic [7:0] idx_reg;
    logic       done_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic [7:0] dest_row_reg;
    logic [7:0] dest_col_reg;
    logic [1:0] status_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] pe_addr;
    logic [ADDR_W-1:0] waddr_ext;
    tag_t              rd_tag;
    logic [2:0]        last_step;
    logic              rd_in_range;
    logic              rd_en;
    logic              wr_en;
    logic [7:0]        cap_byte;
    logic [7:0]        idx_val;
    logic              and_bit;

    assign pop         = (state_reg == S_IDLE) && !q_empty;
    assign waddr_ext   = ADDR_W'(q_head.waddr);
    assign wr_en       = pop && (q_head.kind == KIND_WRITE) && (waddr_ext < STORE_LIMIT);
    assign pe_addr     = ADDR_W'({idx_reg, 2'b00});
    assign rd_in_range = (rd_addr < STORE_LIMIT);
    assign rd_en       = (state_reg == S_READ) && rd_in_range;
    assign cap_byte    = oob_reg ? 8'd0 : rdata_reg;
    assign and_bit     = and_reg[3'd7 - ent_reg.x[2:0]];

    // Read schedule: address and destination for each step of a pixel.
    always_comb
    begin
        rd_addr   = ent_reg.col_addr;
        rd_tag    = TAG_NONE;
        last_step = 3'd3;
        unique case (ent_reg.mode) inside
            MODE_PAL1, MODE_PAL4, MODE_PAL8:
            begin
                last_step = 3'd4;
                case (step_reg)
                    3'd0:    begin rd_addr = ent_reg.col_addr;  rd_tag = TAG_IDX; end
                    3'd1:    begin rd_addr = ent_reg.and_addr;  rd_tag = TAG_AND; end
                    3'd2:    begin rd_addr = pe_addr;           rd_tag = TAG_B;   end
                    3'd3:    begin rd_addr = pe_addr + 1'b1;    rd_tag = TAG_G;   end
                    default: begin rd_addr = pe_addr + 2'd2;    rd_tag = TAG_R;   end
                endcase
            end
            MODE_RGB:
            begin
                case (step_reg)
                    3'd0:    begin rd_addr = ent_reg.col_addr;        rd_tag = TAG_B;   end
                    3'd1:    begin rd_addr = ent_reg.col_addr + 1'b1; rd_tag = TAG_G;   end
                    3'd2:    begin rd_addr = ent_reg.col_addr + 2'd2; rd_tag = TAG_R;   end
                    default: begin rd_addr = ent_reg.and_addr;        rd_tag = TAG_AND; end
                endcase
            end
            default:
            begin
                case (step_reg)
                    3'd0:    begin rd_addr = ent_reg.col_addr;        rd_tag = TAG_B; end
                    3'd1:    begin rd_addr = ent_reg.col_addr + 1'b1; rd_tag = TAG_G; end
                    3'd2:    begin rd_addr = ent_reg.col_addr + 2'd2; rd_tag = TAG_R; end
                    default: begin rd_addr = ent_reg.col_addr + 2'd3; rd_tag = TAG_A; end
                endcase
            end
        endcase
    end

    // Palette index taken out of the color mask byte.
    always_comb
    begin
        case (ent_reg.mode)
            MODE_PAL1: idx_val = {7'd0, cap_byte[3'd7 - ent_reg.x[2:0]]};
            MODE_PAL4: idx_val = ent_reg.x[0] ? {4'd0, cap_byte[3:0]} : {4'd0, cap_byte[7:4]};
            default:   idx_val = cap_byte;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = 3'd0;
                if (pop && (q_head.kind == KIND_PIXEL))
                    state_next = (q_head.status == STATUS_OK) ? S_READ : S_FIN;
            end
            S_READ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == last_step)
                    state_next = S_WAIT;
            end
            S_WAIT: state_next = S_FIN;
            S_FIN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            tag_reg   <= TAG_NONE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            tag_reg   <= (state_reg == S_READ) ? rd_tag : TAG_NONE;
            done_reg  <= (state_reg == S_FIN);
        end
    end

    // Frame store: one write or one read per cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr_ext[MEM_AW-1:0]] <= q_head.wdata;
        if (rd_en)
            rdata_reg <= mem[rd_addr[MEM_AW-1:0]];
    end

    // Transaction capture and byte steering.
    always_ff @(posedge clk)
    begin
        if (pop)
            ent_reg <= q_head;
        oob_reg <= !rd_in_range;
        case (tag_reg)
            TAG_B:   b_reg   <= cap_byte;
            TAG_G:   g_reg   <= cap_byte;
            TAG_R:   r_reg   <= cap_byte;
            TAG_A:   a_reg   <= cap_byte;
            TAG_AND: and_reg <= cap_byte;
            TAG_IDX: idx_reg <= idx_val;
            default: ;
        endcase
    end

    // Result registers; an error result carries zeros.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN)
        begin
            status_reg <= ent_reg.status;
            if (ent_reg.status != STATUS_OK)
            begin
                red_reg      <= 8'd0;
                green_reg    <= 8'd0;
                blue_reg     <= 8'd0;
                alpha_reg    <= 8'd0;
                dest_row_reg <= 8'd0;
                dest_col_reg <= 8'd0;
            end
            else
            begin
                red_reg      <= r_reg;
                green_reg    <= g_reg;
                blue_reg     <= b_reg;
                if (ent_reg.mode == MODE_RGBA)
                    alpha_reg <= a_reg;
                else
                    alpha_reg <= and_bit ? ALPHA_CLEAR : ALPHA_OPAQUE;
                dest_row_reg <= ent_reg.dest_row;
                dest_col_reg <= ent_reg.x;
            end
        end
    end

    assign done     = done_reg;
    assign red      = red_reg;
    assign green    = green_reg;
    assign blue     = blue_reg;
    assign alpha    = alpha_reg;
    assign dest_row = dest_row_reg;
    assign dest_col = dest_col_reg;
    assign status   = status_reg;

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN))
        else $error("result strobe without a finishing step");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |->
            (red == 8'd0) && (green == 8'd0) && (blue == 8'd0) && (alpha == 8'd0)
            && (dest_row == 8'd0) && (dest_col == 8'd0))
        else $error("error result carries nonzero payload");

    a_read_only_good_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (ent_reg.kind == KIND_PIXEL) && (ent_reg.status == STATUS_OK))
        else $error("store read for a transaction that needs none");

endmodule

`default_nettype wire

@@ hdl/ico_dib_pixel_decoder.sv @@
// Channel        Ports                                            Transfer
// -------------  -----------------------------------------------  -------------------------
// command        start, busy, kind, byte_address, data_byte,      start && !busy
//                pixel_x, pixel_y
// result         done, red, green, blue, alpha, dest_row,         done, one cycle, no stall
//                dest_col, status
// configuration  cfg_we, cfg_index, cfg_wdata                     cfg_we
//
// The front takes a transaction, classifies it, works out a pixel's store addresses and
// hands it through a two-entry queue to the back, which owns the single-port frame store.
// The back writes a byte as it pops it; an error pixel goes straight to its finishing step,
// and a good pixel first reads its bytes one after another from the store, so the store port
// sets the sustained pixel rate; done rises in the cycle after the back finishes.
// rst_n clears all control state and loads the register reset values; the frame store
// keeps no reset. Results cannot be held off by the receiver.
`default_nettype none

module ico_dib_pixel_decoder #(
    parameter int STORE_BYTES = 524288
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [18:0] byte_address,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  pixel_y,
    output logic             done,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic [7:0]       dest_row,
    output logic [7:0]       dest_col,
    output logic [1:0]       status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_wdata
);
    import idpd_pkg::*;

    cfg_t   cfg_reg;
    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    entry_t push_data;
    entry_t q_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= 9'd16;
            cfg_reg.image_rows     <= 9'd16;
            cfg_reg.bits_per_pixel <= DEPTH_32;
            cfg_reg.palette_colors <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_wdata;
                CFG_IMAGE_ROWS:     cfg_reg.image_rows     <= cfg_wdata;
                CFG_BITS_PER_PIXEL: cfg_reg.bits_per_pixel <= cfg_wdata[5:0];
                CFG_PALETTE_COLORS: cfg_reg.palette_colors <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Front: accepts and classifies transactions, works out store addresses.
    idpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .byte_address (byte_address),
        .data_byte    (data_byte),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cfg          (cfg_reg),
        .q_full       (q_full),
        .push         (push),
        .push_data    (push_data)
    );

    // Queue between the two halves.
    idpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back: frame store access and result formatting.
    idpd_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (pop),
        .done     (done),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha    (alpha),
        .dest_row (dest_row),
        .dest_col (dest_col),
        .status   (status)
    );

endmodule

`default_nettype wire

@@ tb/sv/idpd_result_checker.sv @@
module idpd_result_checker
    import idpd_pkg::*;
#(
    parameter int STORE_BYTES = 524288
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        kind,
    input  wire logic [18:0] byte_address,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  pixel_y,
    input  wire logic        done,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  alpha,
    input  wire logic [7:0]  dest_row,
    input  wire logic [7:0]  dest_col,
    input  wire logic [1:0]  status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_wdata,
    output int               mismatch_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded pixel as the result port presents it.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] dest_row;
        logic [7:0] dest_col;
        logic [1:0] status;
    } pixel_result_t;

    // Private copy of the frame bytes and the configuration registers.
    logic [7:0]    frame_bytes [int unsigned];
    logic [8:0]    width_reg;
    logic [8:0]    rows_reg;
    logic [5:0]    depth_reg;
    logic [7:0]    palette_reg;
    pixel_result_t expected_pixels [$];
    int            mismatches = 0;
    int            pending = 0;

    assign mismatch_count = mismatches;
    assign pending_count  = pending;

    // Bytes outside the store read back as zero.
    function automatic logic [7:0] store_byte(input int unsigned addr);
        if (addr < STORE_BYTES && frame_bytes.exists(addr))
            return frame_bytes[addr];
        return 8'h00;
    endfunction

    // Works out the result of one pixel transaction from the current frame and registers.
    function automatic pixel_result_t decode_pixel(input logic [7:0] x, input logic [7:0] y);
        int unsigned   w;
        int unsigned   h;
        int unsigned   depth;
        int unsigned   colors;
        int unsigned   pitch;
        int unsigned   mask_pitch;
        int unsigned   color_base;
        int unsigned   row_base;
        int unsigned   mask_byte;
        int unsigned   packed_byte;
        int unsigned   entry;
        int unsigned   pix_addr;
        pixel_result_t res;

        res = '0;
        w = (width_reg > MAX_SIDE) ? MAX_SIDE : width_reg;
        h = (rows_reg > MAX_SIDE) ? MAX_SIDE : rows_reg;
        depth = depth_reg;

        // The depth is judged before the position; errors carry all-zero fields.
        if (!(depth_reg == DEPTH_1 || depth_reg == DEPTH_4 || depth_reg == DEPTH_8 ||
              depth_reg == DEPTH_24 || depth_reg == DEPTH_32)) begin
            res.status = STATUS_DEPTH;
            return res;
        end
        if (x >= w || y >= h) begin
            res.status = STATUS_RANGE;
            return res;
        end

        // A zero palette count below 16 bits means a full palette.
        colors = palette_reg;
        if (depth < 16 && colors == 0)
            colors = 1 << depth;

        // Rows of both masks are padded to whole 32-bit words.
        pitch = ((depth * w + 31) / 32) * 4;
        mask_pitch = ((w + 31) / 32) * 4;
        color_base = colors * 4;
        row_base = color_base + y * pitch;
        mask_byte = store_byte(color_base + h * pitch + y * mask_pitch + x / 8);
        res.alpha = ((mask_byte >> (7 - x[2:0])) & 1) ? ALPHA_CLEAR : ALPHA_OPAQUE;

        if (depth <= 8) begin
            // Palette depths: fetch the index, then the entry, even past the palette count.
            case (depth_reg)
                DEPTH_1: entry = (store_byte(row_base + x / 8) >> (7 - x[2:0])) & 1;
                DEPTH_4:
                begin
                    packed_byte = store_byte(row_base + x / 2);
                    entry = x[0] ? packed_byte[3:0] : packed_byte[7:4];
                end
                default: entry = store_byte(row_base + x);
            endcase
            res.blue  = store_byte(entry * 4);
            res.green = store_byte(entry * 4 + 1);
            res.red   = store_byte(entry * 4 + 2);
        end else begin
            // Direct color, with alpha from the fourth byte at 32 bits.
            pix_addr = row_base + x * (depth / 8);
            res.blue  = store_byte(pix_addr);
            res.green = store_byte(pix_addr + 1);
            res.red   = store_byte(pix_addr + 2);
            if (depth_reg == DEPTH_32)
                res.alpha = store_byte(pix_addr + 3);
        end

        res.dest_row = 8'(h - 1 - y);
        res.dest_col = x;
        res.status = STATUS_OK;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, field, want, got);
            mismatches++;
        end
    endtask

    // Watch all three channels at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        pixel_result_t want;

        if (!rst_n) begin
            width_reg = 9'd16;
            rows_reg = 9'd16;
            depth_reg = 6'd32;
            palette_reg = 8'd0;
            expected_pixels.delete();
            pending = 0;
        end else begin
            // Results are compared first so a transaction accepted now cannot mask one.
            if (done) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result with no pixel transaction pending, status %0d",
                             $time, status);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("alpha", want.alpha, alpha);
                    check_field("dest_row", want.dest_row, dest_row);
                    check_field("dest_col", want.dest_col, dest_col);
                    check_field("status", 8'(want.status), 8'(status));
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:    width_reg = cfg_wdata;
                    CFG_IMAGE_ROWS:     rows_reg = cfg_wdata;
                    CFG_BITS_PER_PIXEL: depth_reg = cfg_wdata[5:0];
                    CFG_PALETTE_COLORS: palette_reg = cfg_wdata[7:0];
                endcase
            end

            // Byte writes update the frame copy; pixels queue their expected result.
            if (start && !busy) begin
                if (kind == KIND_WRITE) begin
                    if (byte_address < STORE_BYTES)
                        frame_bytes[byte_address] = data_byte;
                end else begin
                    expected_pixels.push_back(decode_pixel(pixel_x, pixel_y));
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import idpd_pkg::*;

    localparam int STORE_BYTES   = 524288;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 520;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        kind = KIND_WRITE;
    logic [18:0] byte_address = '0;
    logic [7:0]  data_byte = '0;
    logic [7:0]  pixel_x = '0;
    logic [7:0]  pixel_y = '0;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  dest_row;
    logic [7:0]  dest_col;
    logic [1:0]  status;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [8:0]  cfg_wdata = '0;
    int          mismatch_count;
    int          pending_count;

    // Register values as last written, used to aim the stimulus.
    int unsigned cfg_width = 16;
    int unsigned cfg_rows = 16;
    int unsigned cfg_depth = 32;
    int unsigned cfg_colors = 0;

    // Bytes already written; a pixel only ever reads bytes from here.
    logic [7:0]  written_bytes [int unsigned];
    int unsigned items_sent = 0;
    bit          burst_mode = 1'b0;
    int          stalled_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ico_dib_pixel_decoder #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .byte_address(byte_address),
        .data_byte(data_byte),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .done(done),
        .red(red),
        .green(green),
        .blue(blue),
        .alpha(alpha),
        .dest_row(dest_row),
        .dest_col(dest_col),
        .status(status),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    idpd_result_checker #(
        .STORE_BYTES(STORE_BYTES)
    ) result_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .byte_address(byte_address),
        .data_byte(data_byte),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .done(done),
        .red(red),
        .green(green),
        .blue(blue),
        .alpha(alpha),
        .dest_row(dest_row),
        .dest_col(dest_col),
        .status(status),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count)
    );

    // Stop the run when no channel has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("** ico_dib_pixel_decoder: FAILED **");
            $finish;
        end
    end

    // Presents one transaction after a random gap and returns at the falling edge after it
    // was taken; start stays high when the next one follows with no gap.
    task automatic send_item(input logic k, input int unsigned addr, input logic [7:0] data,
                             input logic [7:0] x, input logic [7:0] y);
        int unsigned gap;

        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        kind = k;
        byte_address = addr[18:0];
        data_byte = data;
        pixel_x = x;
        pixel_y = y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_write(input int unsigned addr, input logic [7:0] data);
        send_item(KIND_WRITE, addr, data, $urandom, $urandom);
        written_bytes[addr] = data;
    endtask

    task automatic ensure_byte(input int unsigned addr);
        if (!written_bytes.exists(addr))
            send_write(addr, $urandom_range(0, 255));
    endtask

    // Writes every byte the pixel will read that is still unwritten, then asks for it.
    task automatic send_pixel(input logic [7:0] x, input logic [7:0] y);
        int unsigned w;
        int unsigned h;
        int unsigned colors;
        int unsigned pitch;
        int unsigned row_base;
        int unsigned addr;
        int unsigned entry;
        bit          supported;

        w = (cfg_width > MAX_SIDE) ? MAX_SIDE : cfg_width;
        h = (cfg_rows > MAX_SIDE) ? MAX_SIDE : cfg_rows;
        supported = (cfg_depth == DEPTH_1 || cfg_depth == DEPTH_4 || cfg_depth == DEPTH_8 ||
                     cfg_depth == DEPTH_24 || cfg_depth == DEPTH_32);
        if (supported && x < w && y < h) begin
            colors = cfg_colors;
            if (cfg_depth < 16 && colors == 0)
                colors = 1 << cfg_depth;
            pitch = ((cfg_depth * w + 31) / 32) * 4;
            row_base = colors * 4 + y * pitch;
            ensure_byte(colors * 4 + h * pitch + y * (((w + 31) / 32) * 4) + x / 8);
            if (cfg_depth <= 8) begin
                addr = row_base + x * cfg_depth / 8;
                ensure_byte(addr);
                if (cfg_depth == DEPTH_1)
                    entry = (written_bytes[addr] >> (7 - x[2:0])) & 1;
                else if (cfg_depth == DEPTH_4)
                    entry = x[0] ? written_bytes[addr][3:0] : written_bytes[addr][7:4];
                else
                    entry = written_bytes[addr];
                for (int i = 0; i < 3; i++)
                    ensure_byte(entry * 4 + i);
            end else begin
                for (int i = 0; i < cfg_depth / 8; i++)
                    ensure_byte(row_base + x * (cfg_depth / 8) + i);
            end
        end
        send_item(KIND_PIXEL, $urandom_range(0, STORE_BYTES - 1), $urandom, x, y);
    endtask

    // Waits until every pixel result is in and the write path has drained.
    task automatic wait_idle();
        start = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input int unsigned value);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_wdata = value[8:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (index)
            CFG_IMAGE_WIDTH:    cfg_width = value[8:0];
            CFG_IMAGE_ROWS:     cfg_rows = value[8:0];
            CFG_BITS_PER_PIXEL: cfg_depth = value[5:0];
            CFG_PALETTE_COLORS: cfg_colors = value[7:0];
        endcase
    endtask

    // One configuration followed by a mix of pixels, mostly inside the frame, and stray writes.
    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int unsigned depth, input int unsigned colors,
                             input int unsigned count);
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned span;
        int unsigned phase_end;
        int unsigned choice;

        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_ROWS, h);
        write_reg(CFG_BITS_PER_PIXEL, depth);
        write_reg(CFG_PALETTE_COLORS, colors);
        w_eff = (cfg_width > MAX_SIDE) ? MAX_SIDE : cfg_width;
        h_eff = (cfg_rows > MAX_SIDE) ? MAX_SIDE : cfg_rows;
        span = 1024 + h_eff * (w_eff * 4 + 36);
        burst_mode = ($urandom_range(0, 3) == 0);
        phase_end = items_sent + count;
        while (items_sent < phase_end) begin
            choice = $urandom_range(0, 99);
            if (choice < 20)
                send_write($urandom_range(0, 1) ? $urandom_range(0, span)
                                                : $urandom_range(0, STORE_BYTES - 1),
                           $urandom_range(0, 255));
            else if (choice < 32 || w_eff == 0 || h_eff == 0)
                send_pixel($urandom_range(0, 255), $urandom_range(0, 255));
            else
                send_pixel($urandom_range(0, w_eff - 1), $urandom_range(0, h_eff - 1));
        end
    endtask

    // Random register picks lean toward small frames and the supported depths.
    function automatic int unsigned pick_side();
        int unsigned roll;

        roll = $urandom_range(0, 9);
        if (roll < 8)
            return $urandom_range(1, 24);
        if (roll == 8)
            return $urandom_range(1, 256);
        return $urandom_range(0, 511);
    endfunction

    function automatic int unsigned pick_depth();
        case ($urandom_range(0, 9))
            0:       return DEPTH_1;
            1:       return DEPTH_4;
            2, 3:    return DEPTH_8;
            4, 5:    return DEPTH_24;
            6, 7:    return DEPTH_32;
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: direct 32-bit color on a 16 by 16 frame.
        send_write(0, 8'hFF);
        send_write(1, 8'h00);
        send_write(2, 8'hA5);
        send_write(3, 8'h5A);
        send_pixel(0, 0);
        send_pixel(15, 15);
        send_pixel(16, 0);
        send_pixel(0, 16);
        send_pixel(255, 255);
        send_write(STORE_BYTES - 1, 8'hFF);

        // An unsupported depth wins over a position outside the frame.
        wait_idle();
        write_reg(CFG_BITS_PER_PIXEL, 0);
        send_pixel(255, 255);
        send_pixel(0, 0);

        // Fixed settings: smallest and largest frames, oversized and zero sides, bad depth.
        run_phase(1, 1, DEPTH_1, 0, 25);
        run_phase(256, 256, DEPTH_32, 255, 30);
        run_phase(511, 300, DEPTH_24, 0, 25);
        run_phase(0, 5, DEPTH_8, 1, 15);
        run_phase(7, 0, DEPTH_4, 16, 15);
        run_phase(6, 5, 63, 0, 15);
        run_phase(33, 9, DEPTH_8, 255, 40);
        run_phase(20, 12, DEPTH_4, 0, 40);

        // Random settings until the item budget is spent.
        while (items_sent < RANDOM_ITEMS)
            run_phase(pick_side(), pick_side(), pick_depth(),
                      $urandom_range(0, 1) ? 0 : $urandom_range(0, 255),
                      $urandom_range(30, 60));

        wait_idle();
        if (mismatch_count == 0 && pending_count == 0)
            $display("** ico_dib_pixel_decoder: PASSED **");
        else
            $display("** ico_dib_pixel_decoder: FAILED **");
        $finish;
    end

endmodule
